### src/hcbd_pkg.sv
// Shared types, constants and a helper function for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_SIZE     = 3'd1,
        PH_SIZE_LF  = 3'd2,
        PH_DATA     = 3'd3,
        PH_TRAIL_CR = 3'd4,
        PH_TRAIL_LF = 3'd5
    } phase_t;

    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_F = 8'd102;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_F = 8'd70;
    localparam logic [7:0] LOWER_BIAS = 8'd87;
    localparam logic [7:0] UPPER_BIAS = 8'd55;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       end_of_body;
    } result_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        logic [7:0] diff;
        r.is_hex = 1'b0;
        r.value  = 4'd0;
        diff     = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff   = c - CH_ZERO;
            r.is_hex = 1'b1;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            diff   = c - LOWER_BIAS;
            r.is_hex = 1'b1;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            diff   = c - UPPER_BIAS;
            r.is_hex = 1'b1;
        end
        r.value = diff[3:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### src/http_chunked_body_decoder_top.sv
// Top level of the chunked transfer body decoder.
`default_nettype none

// The decoder takes one response byte per transaction and accepts a new byte in every
// cycle while the output side keeps up, so the sustained rate is one byte per clock.
// A byte is decoded while it is held in the input register, and its result is written to
// the output register at the edge at which the core takes the byte, so a payload byte
// passes through the input register and then the output register before it can be taken.
// The header is discarded up to the first CR LF CR LF, each hex size line is read, the
// payload bytes are passed with end_of_body low, and a zero size yields one transaction
// with data_byte zero and end_of_body high before header search starts again.

module http_chunked_body_decoder_top
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      data_byte,
    output logic            end_of_body
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       can_take;
    logic       fire;
    result_t    res;

    assign fire = byte_valid && can_take;

    hcbd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .take       (can_take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_data (byte_data),
        .res       (res)
    );

    hcbd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .can_take    (can_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .end_of_body (end_of_body)
    );

endmodule

`default_nettype wire

### src/hcbd_in_stage.sv
// Input register that holds one received byte until the decoder core takes it.
`default_nettype none

module hcbd_in_stage
    import hcbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

### src/hcbd_core.sv
// Decoder state machine that turns one byte into zero or one result per step.
`default_nettype none

module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] byte_data,
    output result_t         res
);

    localparam logic [SIZE_BITS-1:0] SIZE_ZERO = '0;
    localparam logic [SIZE_BITS-1:0] SIZE_ONE  = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [1:0]           match_reg;
    logic [1:0]           match_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] size_next;
    logic [SIZE_BITS-1:0] remain_reg;
    logic [SIZE_BITS-1:0] remain_next;
    hex_digit_t           digit;
    logic [7:0]           want;

    assign digit = hex_decode(byte_data);
    assign want  = match_reg[0] ? CH_LF : CH_CR;

    always_comb
    begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (byte_data == CH_CR)
                    begin
                        phase_next = PH_SIZE_LF;
                    end
                    else if (digit.is_hex)
                    begin
                        size_next = {size_reg[SIZE_BITS-5:0], digit.value};
                    end
                end
                PH_SIZE_LF:
                begin
                    if (size_reg == SIZE_ZERO)
                    begin
                        phase_next  = PH_HEADER;
                        match_next  = 2'd0;
                        remain_next = SIZE_ZERO;
                    end
                    else
                    begin
                        remain_next = size_reg;
                        size_next   = SIZE_ZERO;
                        phase_next  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    remain_next = remain_reg - SIZE_ONE;
                    if (remain_reg == SIZE_ONE)
                    begin
                        phase_next = PH_TRAIL_CR;
                    end
                end
                PH_TRAIL_CR:
                begin
                    phase_next = PH_TRAIL_LF;
                end
                PH_TRAIL_LF:
                begin
                    phase_next = PH_SIZE;
                    size_next  = SIZE_ZERO;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (byte_data == want)
                    begin
                        if (match_reg == 2'd3)
                        begin
                            match_next  = 2'd0;
                            size_next   = SIZE_ZERO;
                            remain_next = SIZE_ZERO;
                            phase_next  = PH_SIZE;
                        end
                        else
                        begin
                            match_next = match_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        match_next = (byte_data == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res.valid       = 1'b0;
        res.data_byte   = 8'd0;
        res.end_of_body = 1'b0;
        unique case (phase_reg)
            PH_SIZE_LF:
            begin
                if (size_reg == SIZE_ZERO)
                begin
                    res.valid       = fire;
                    res.end_of_body = 1'b1;
                end
            end
            PH_DATA:
            begin
                res.valid     = fire;
                res.data_byte = byte_data;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            match_reg  <= 2'd0;
            size_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
        end
    end

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (remain_reg != SIZE_ZERO))
        else $error("Data phase entered with no bytes remaining.");

    a_end_returns_header: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.end_of_body) |=> (phase_reg == PH_HEADER && match_reg == 2'd0))
        else $error("End marker did not return the decoder to header search.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (fire && (phase_reg == PH_DATA || phase_reg == PH_SIZE_LF)))
        else $error("Result produced outside the data or size line phases.");

endmodule

`default_nettype wire

### src/hcbd_out_stage.sv
// Output register that holds one result until the downstream side takes it.
`default_nettype none

module hcbd_out_stage
    import hcbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire result_t  res,
    output logic          can_take,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [7:0]    data_byte,
    output logic          end_of_body
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       eob_reg;

    assign can_take   = !valid_reg || !out_stall;
    assign valid_next = can_take ? res.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res.valid)
        begin
            data_reg <= res.data_byte;
            eob_reg  <= res.end_of_body;
        end
    end

    assign out_valid   = valid_reg;
    assign data_byte   = data_reg;
    assign end_of_body = eob_reg;

endmodule

`default_nettype wire
